// ----- hw/rtl/sdq_pkg.sv -----
// Shared types and constants for the switch debounce qualifier.
package sdq_pkg;

	localparam int unsigned SW_IDX_W   = 4;
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Opcodes of an input item.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_APPLY  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION_MS = 2'd2;

	typedef struct packed {
		logic                opcode;
		logic [SW_IDX_W-1:0] switch_index;
		logic                signal_level;
		logic [TIME_W-1:0]   now_ms;
		logic                current_level;
	} in_item_t;

	typedef struct packed {
		logic state_changed;
		logic debounced_state;
		logic target_level;
	} out_item_t;

	// One switch record.
	typedef struct packed {
		logic [COUNT_W-1:0] sample_count;
		logic [TIME_W-1:0]  first_seen_ms;
		logic               pending_level;
		logic               accepted_level;
		logic               change_flag;
	} rec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

endpackage

// ----- hw/rtl/sdq_datapath.sv -----
// Datapath: configuration registers, switch record table and update logic.
module sdq_datapath #(
	parameter int NUM_SWITCHES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sdq_pkg::cmd_t                       cmd,
	input  sdq_pkg::in_item_t                   item,
	input  logic                                cfg_we,
	input  logic [sdq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sdq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output sdq_pkg::out_item_t                  result
);

	// Only sixteen records can ever be addressed by the index field.
	localparam int DEPTH = (NUM_SWITCHES < 16) ? NUM_SWITCHES : 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [31:0] NUM_LIMIT = 32'(NUM_SWITCHES);

	logic                            toggle_mode_q;
	logic [sdq_pkg::COUNT_W-1:0]     min_samples_q;
	logic [sdq_pkg::TIME_W-1:0]      min_duration_q;

	sdq_pkg::in_item_t               item_q;
	sdq_pkg::rec_t                   table_q [DEPTH];
	sdq_pkg::out_item_t              result_q;

	logic [IDX_W-1:0]                idx;
	logic                            in_range;
	sdq_pkg::rec_t                   rec_rd;
	sdq_pkg::rec_t                   rec_nx;
	sdq_pkg::out_item_t              res_nx;

	assign idx      = item_q.switch_index[IDX_W-1:0];
	assign in_range = 32'(item_q.switch_index) < NUM_LIMIT;
	assign rec_rd   = in_range ? table_q[idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_mode_q  <= 1'b0;
			min_samples_q  <= '0;
			min_duration_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdq_pkg::REG_TOGGLE_MODE:     toggle_mode_q  <= cfg_wdata[0];
				sdq_pkg::REG_MIN_SAMPLES:     min_samples_q  <= cfg_wdata[sdq_pkg::COUNT_W-1:0];
				sdq_pkg::REG_MIN_DURATION_MS: min_duration_q <= cfg_wdata[sdq_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			result_q <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				table_q[i] <= '0;
			end
		end else if (cmd.exec && in_range) begin
			table_q[idx] <= rec_nx;
		end
	end

	// Record update for the held item.
	always_comb begin
		logic [sdq_pkg::COUNT_W-1:0] cnt_inc;
		logic [sdq_pkg::TIME_W-1:0]  first_use;
		logic [sdq_pkg::TIME_W-1:0]  dur;
		logic                        qual;
		logic                        tgt;

		cnt_inc = (rec_rd.sample_count == sdq_pkg::COUNT_MAX) ?
			rec_rd.sample_count : rec_rd.sample_count + 1'b1;
		first_use = (!toggle_mode_q && rec_rd.sample_count == '0) ?
			item_q.now_ms : rec_rd.first_seen_ms;
		dur  = item_q.now_ms - first_use;
		qual = (cnt_inc >= min_samples_q) && (dur >= min_duration_q);
		rec_nx = rec_rd;

		if (item_q.opcode == sdq_pkg::OP_SAMPLE) begin
			if (!toggle_mode_q) begin
				if (item_q.signal_level) begin
					rec_nx.first_seen_ms = first_use;
					rec_nx.sample_count  = cnt_inc;
					if (qual && !rec_rd.pending_level) begin
						rec_nx.accepted_level = 1'b1;
						rec_nx.pending_level  = 1'b1;
						rec_nx.change_flag    = 1'b1;
					end
				end else begin
					rec_nx.sample_count  = '0;
					rec_nx.first_seen_ms = '0;
					rec_nx.pending_level = 1'b0;
				end
			end else if (rec_rd.accepted_level != item_q.signal_level) begin
				if (rec_rd.pending_level == item_q.signal_level) begin
					rec_nx.sample_count = cnt_inc;
					if (qual) begin
						rec_nx.change_flag    = 1'b1;
						rec_nx.accepted_level = item_q.signal_level;
					end
				end else begin
					rec_nx.first_seen_ms = item_q.now_ms;
					rec_nx.sample_count  = sdq_pkg::COUNT_W'(1);
					rec_nx.pending_level = item_q.signal_level;
				end
			end
		end else begin
			rec_nx.change_flag = 1'b0;
			if (toggle_mode_q) begin
				rec_nx.sample_count  = '0;
				rec_nx.first_seen_ms = '0;
			end else begin
				rec_nx.accepted_level = 1'b0;
			end
		end

		if (toggle_mode_q) begin
			tgt = rec_nx.accepted_level;
		end else begin
			tgt = item_q.current_level ^ rec_nx.accepted_level;
		end

		if (in_range) begin
			res_nx.state_changed   = rec_nx.change_flag;
			res_nx.debounced_state = rec_nx.accepted_level;
			res_nx.target_level    = tgt;
		end else begin
			res_nx = '0;
		end
	end

	assign result = result_q;

endmodule

// ----- hw/rtl/sdq_ctrl.sv -----
// Controller: item sequencing and result register handshake.
module sdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	output logic          result_valid,
	input  logic          result_ready,
	output sdq_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   result_valid_q;

	assign item_ready  = (state_q == ST_IDLE);
	assign cmd.capture = item_valid && item_ready;
	assign cmd.exec    = (state_q == ST_EXEC) && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.exec) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	a_capture_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_EXEC)
		else $error("captured item did not move the controller to execute");

	a_exec_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> result_valid_q && state_q == ST_IDLE)
		else $error("execute did not present a result and return to idle");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result appeared without an executed item");

endmodule

// ----- hw/rtl/switch_debounce_qualifier_core.sv -----
// Top level of the switch debounce qualifier: controller plus datapath.
//
// This block debounces up to sixteen switches held in a table of records. Each
// input item names a switch and either feeds it one raw sample with a
// millisecond timestamp or acknowledges a pending change; every item yields
// exactly one result item with the change flag, the debounced state and the
// level to drive. An item is captured in the cycle it is accepted; in the execute
// state its switch record is read, updated and written back and the result
// register is loaded. The two-state controller takes no new item until the
// current one has executed; execution stretches only while an earlier result
// still sits unaccepted in the result register. A new item is accepted while a
// finished result waits to be taken. The configuration registers (toggle mode,
// minimum sample count, minimum duration) are written through the plain write
// port; the user must write them only while no item is in flight, and the block
// itself does not enforce this. Indexes beyond the register list are ignored.
// Reset clears all records, so no clearing pass is needed.
module switch_debounce_qualifier_core #(
	parameter int NUM_SWITCHES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  sdq_pkg::in_item_t              item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output sdq_pkg::out_item_t             result,
	input  logic                           cfg_we,
	input  logic [sdq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// Command bundle from the controller into the datapath.
	sdq_pkg::cmd_t cmd;

	sdq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	sdq_datapath #(
		.NUM_SWITCHES (NUM_SWITCHES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

endmodule

// ----- bench/sdq_checker.sv -----
// Result checker for the switch debounce qualifier: tracks registers, predicts, compares.
module sdq_checker #(
	parameter int NUM_SWITCHES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_ready,
	input  sdq_pkg::in_item_t              item,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  sdq_pkg::out_item_t             result,
	input  logic                           cfg_we,
	input  logic [sdq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             mismatch_count,
	output int                             results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic                        mode_toggle;
	logic [sdq_pkg::COUNT_W-1:0] min_samples_q;
	logic [sdq_pkg::TIME_W-1:0]  min_duration_q;
	sdq_pkg::rec_t               switch_table [NUM_SWITCHES];
	sdq_pkg::out_item_t          expected_results [$];
	int                          mismatches = 0;
	int                          owed = 0;
	int                          results_seen = 0;

	assign mismatch_count = mismatches;
	assign results_owed   = owed;

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: result %0d: %s", $realtime, results_seen, msg);
		mismatches++;
	endtask

	// Applies one item to the switch table and returns the result it must produce.
	function automatic sdq_pkg::out_item_t debounce_step(sdq_pkg::in_item_t it);
		sdq_pkg::rec_t              r;
		sdq_pkg::out_item_t         res;
		logic [sdq_pkg::TIME_W-1:0] held_ms;
		int unsigned                sw;
		res = '0;
		sw  = 32'(it.switch_index);
		if (sw >= NUM_SWITCHES)
			return res;
		r = switch_table[sw];
		if (it.opcode == sdq_pkg::OP_SAMPLE) begin
			if (!mode_toggle) begin
				if (it.signal_level) begin
					if (r.sample_count == '0)
						r.first_seen_ms = it.now_ms;
					if (r.sample_count != sdq_pkg::COUNT_MAX)
						r.sample_count = r.sample_count + 1'b1;
					held_ms = it.now_ms - r.first_seen_ms;
					if (r.sample_count >= min_samples_q && held_ms >= min_duration_q &&
					    r.pending_level != 1'b1) begin
						r.accepted_level = 1'b1;
						r.pending_level  = 1'b1;
						r.change_flag    = 1'b1;
					end
				end else begin
					r.sample_count  = '0;
					r.first_seen_ms = '0;
					r.pending_level = 1'b0;
				end
			end else if (r.accepted_level != it.signal_level) begin
				if (r.pending_level == it.signal_level) begin
					if (r.sample_count != sdq_pkg::COUNT_MAX)
						r.sample_count = r.sample_count + 1'b1;
					held_ms = it.now_ms - r.first_seen_ms;
					if (r.sample_count >= min_samples_q && held_ms >= min_duration_q) begin
						r.change_flag    = 1'b1;
						r.accepted_level = it.signal_level;
					end
				end else begin
					r.first_seen_ms = it.now_ms;
					r.sample_count  = sdq_pkg::COUNT_W'(1);
					r.pending_level = it.signal_level;
				end
			end
		end else begin
			r.change_flag = 1'b0;
			if (mode_toggle) begin
				r.sample_count  = '0;
				r.first_seen_ms = '0;
			end else begin
				r.accepted_level = 1'b0;
			end
		end
		switch_table[sw] = r;
		res.state_changed   = r.change_flag;
		res.debounced_state = r.accepted_level;
		if (mode_toggle)
			res.target_level = r.accepted_level;
		else
			res.target_level = r.accepted_level ? ~it.current_level : it.current_level;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		sdq_pkg::out_item_t want;
		if (!arst_n) begin
			mode_toggle    = 1'b0;
			min_samples_q  = '0;
			min_duration_q = '0;
			for (int i = 0; i < NUM_SWITCHES; i++)
				switch_table[i] = '0;
			expected_results.delete();
			owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sdq_pkg::REG_TOGGLE_MODE:     mode_toggle    = cfg_wdata[0];
					sdq_pkg::REG_MIN_SAMPLES:
						min_samples_q  = cfg_wdata[sdq_pkg::COUNT_W-1:0];
					sdq_pkg::REG_MIN_DURATION_MS:
						min_duration_q = cfg_wdata[sdq_pkg::TIME_W-1:0];
					default: ;
				endcase
			end
			// A result leaving now belongs to an earlier item, so it is checked first.
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result arrived with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (result.state_changed !== want.state_changed)
						report_mismatch($sformatf("state_changed %b, expected %b",
							result.state_changed, want.state_changed));
					if (result.debounced_state !== want.debounced_state)
						report_mismatch($sformatf("debounced_state %b, expected %b",
							result.debounced_state, want.debounced_state));
					if (result.target_level !== want.target_level)
						report_mismatch($sformatf("target_level %b, expected %b",
							result.target_level, want.target_level));
				end
				results_seen++;
			end
			if (item_valid && item_ready)
				expected_results.push_back(debounce_step(item));
			owed = expected_results.size();
		end
	end

endmodule

// ----- bench/switch_debounce_qualifier_core_tb.sv -----
// Top of the switch debounce qualifier bench: clock, reset, stimulus and verdict.
module switch_debounce_qualifier_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SWITCHES = 16;
	// Cycles without any handshake or register write before the run is declared hung.
	localparam int QUIET_LIMIT  = 1000;
	localparam int PHASE_ITEMS  = 112;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           item_valid   = 1'b0;
	logic                           item_ready;
	sdq_pkg::in_item_t              item         = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	sdq_pkg::out_item_t             result;
	logic                           cfg_we       = 1'b0;
	logic [sdq_pkg::CFG_IDX_W-1:0]  cfg_index    = sdq_pkg::REG_TOGGLE_MODE;
	logic [sdq_pkg::CFG_DATA_W-1:0] cfg_wdata    = '0;

	int mismatch_count;
	int results_owed;

	// When set, both the sender and the receiver insert short random pauses.
	logic                       idle_on    = 1'b0;
	int                         stall_left = 0;
	logic [sdq_pkg::TIME_W-1:0] time_base [NUM_SWITCHES];
	logic                       last_level [NUM_SWITCHES];

	switch_debounce_qualifier_core #(
		.NUM_SWITCHES(NUM_SWITCHES)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	sdq_checker #(
		.NUM_SWITCHES(NUM_SWITCHES)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatch_count(mismatch_count),
		.results_owed  (results_owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic sdq_pkg::in_item_t make_item(logic op,
		logic [sdq_pkg::SW_IDX_W-1:0] sw, logic lvl, logic [sdq_pkg::TIME_W-1:0] now,
		logic cur);
		sdq_pkg::in_item_t it;
		it.opcode        = op;
		it.switch_index  = sw;
		it.signal_level  = lvl;
		it.now_ms        = now;
		it.current_level = cur;
		return it;
	endfunction

	// Presents one item at a falling edge and holds it until the block takes it. With idling on,
	// a short burst of empty cycles may come first. Valid stays high after acceptance so that
	// back-to-back items never lower and raise it within one time step.
	task automatic send_item(sdq_pkg::in_item_t it);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	// Drops valid and waits until every expected result has been taken, then lets the
	// pipeline settle before anything else happens.
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes all three registers in consecutive cycles; only called while the block is idle.
	task automatic configure(logic toggle, logic [sdq_pkg::COUNT_W-1:0] min_cnt,
		logic [sdq_pkg::TIME_W-1:0] min_ms);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sdq_pkg::REG_TOGGLE_MODE;
		cfg_wdata <= sdq_pkg::CFG_DATA_W'(toggle);
		@(negedge clk);
		cfg_index <= sdq_pkg::REG_MIN_SAMPLES;
		cfg_wdata <= sdq_pkg::CFG_DATA_W'(min_cnt);
		@(negedge clk);
		cfg_index <= sdq_pkg::REG_MIN_DURATION_MS;
		cfg_wdata <= sdq_pkg::CFG_DATA_W'(min_ms);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// A phase of random items. Most items form plausible switch activity: a few neighboring
	// switches, each with its own clock that creeps forward and a level that mostly holds, so
	// that qualification actually completes. About one item in ten is pure noise over every
	// field. Idling is switched on and off in stretches unless the phase forbids it.
	task automatic random_phase(int count, logic allow_idle);
		sdq_pkg::in_item_t it;
		int                base_sw;
		int                sw;
		logic              op;
		base_sw = $urandom_range(0, NUM_SWITCHES - 4);
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			// Half the clocks start just short of the wrap point.
			time_base[i]  = $urandom_range(0, 1) ? sdq_pkg::TIME_W'($urandom) :
				sdq_pkg::TIME_W'(32'hFFFF_FFC0 + $urandom_range(0, 63));
			last_level[i] = 1'($urandom_range(0, 1));
		end
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0)
				idle_on = allow_idle && ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 9) == 0) begin
				it = make_item(1'($urandom_range(0, 1)),
					sdq_pkg::SW_IDX_W'($urandom_range(0, NUM_SWITCHES - 1)),
					1'($urandom_range(0, 1)), sdq_pkg::TIME_W'($urandom),
					1'($urandom_range(0, 1)));
			end else begin
				sw = base_sw + $urandom_range(0, 3);
				if ($urandom_range(0, 6) == 0)
					last_level[sw] = ~last_level[sw];
				time_base[sw] = time_base[sw] + sdq_pkg::TIME_W'($urandom_range(0, 4));
				op = ($urandom_range(0, 9) == 0) ? sdq_pkg::OP_APPLY : sdq_pkg::OP_SAMPLE;
				it = make_item(op, sdq_pkg::SW_IDX_W'(sw), last_level[sw], time_base[sw],
					1'($urandom_range(0, 1)));
			end
			send_item(it);
		end
		// Every phase ends with the sender holding off until all results are back.
		wait_idle();
	endtask

	// The receiver stalls in random bursts while idling is on.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// The watchdog ends a run that stops making progress, which also catches results that never
	// arrive.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed items, first under the reset settings: push-button service with no minimums.
		// A high sample at time zero is accepted at once, since zero is an ordinary timestamp.
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd0, 1'b1, 32'h0000_0000, 1'b0));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd0, 1'b1, 32'hFFFF_FFFF, 1'b1));
		// An apply clears the change and the state whatever signal_level says.
		send_item(make_item(sdq_pkg::OP_APPLY, 4'd0, 1'b0, 32'h0000_0000, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd15, 1'b0, 32'h0000_0000, 1'b0));
		send_item(make_item(sdq_pkg::OP_APPLY, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0));
		wait_idle();

		// Push-button with both minimums: the level persists across the timestamp wrap and is
		// accepted on the sample where the wrapped duration reaches ten milliseconds.
		configure(1'b0, 16'd3, 32'd10);
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd15, 1'b1, 32'hFFFF_FFFA, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd15, 1'b1, 32'hFFFF_FFFE, 1'b0));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd15, 1'b1, 32'h0000_0003, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd15, 1'b1, 32'h0000_0004, 1'b0));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd15, 1'b0, 32'h0000_0005, 1'b1));
		send_item(make_item(sdq_pkg::OP_APPLY, 4'd15, 1'b0, 32'h0000_0006, 1'b0));
		wait_idle();

		// Toggle service: a new level restarts qualification, a repeated one is accepted, and a
		// sample equal to the accepted state is ignored.
		configure(1'b1, 16'd2, 32'd0);
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd5, 1'b1, 32'd100, 1'b0));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd5, 1'b1, 32'd100, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd5, 1'b1, 32'd101, 1'b0));
		send_item(make_item(sdq_pkg::OP_APPLY, 4'd5, 1'b0, 32'd150, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd5, 1'b0, 32'd200, 1'b0));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd5, 1'b1, 32'd201, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd5, 1'b0, 32'd202, 1'b0));
		wait_idle();

		// Switching the service at run time works on the record the other service left behind.
		configure(1'b0, 16'd0, 32'd0);
		send_item(make_item(sdq_pkg::OP_APPLY, 4'd5, 1'b1, 32'd300, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd5, 1'b1, 32'd301, 1'b1));
		send_item(make_item(sdq_pkg::OP_SAMPLE, 4'd7, 1'b0, 32'd302, 1'b0));
		send_item(make_item(sdq_pkg::OP_APPLY, 4'd7, 1'b0, 32'd303, 1'b0));
		wait_idle();

		// Random phases over a spread of settings, the extremes among them.
		configure(1'b0, 16'd0, 32'd0);
		random_phase(PHASE_ITEMS, 1'b1);
		configure(1'b0, 16'd3, 32'd6);
		random_phase(PHASE_ITEMS, 1'b1);
		configure(1'b1, 16'd2, 32'd5);
		random_phase(PHASE_ITEMS, 1'b1);
		configure(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
		random_phase(PHASE_ITEMS, 1'b1);
		configure(1'b0, 16'hFFFF, 32'd0);
		random_phase(PHASE_ITEMS, 1'b1);
		configure(1'b1, 16'd0, 32'd0);
		random_phase(PHASE_ITEMS, 1'b1);
		configure(1'b0, 16'($urandom_range(0, 8)), 32'($urandom_range(0, 20)));
		random_phase(PHASE_ITEMS, 1'b1);
		// The closing phase runs with no idling on either side.
		configure(1'b1, 16'($urandom_range(0, 8)), 32'($urandom_range(0, 20)));
		random_phase(PHASE_ITEMS, 1'b0);

		// Give any stray result time to show up before the verdict.
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
